// File: rtl/vsht_pkg.sv
`default_nettype none

package vsht_pkg;

    localparam int NSENS  = 4;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 3;
    localparam int TEMP_W = 14;
    localparam int LIM_W  = 12;
    localparam int HH_W   = 10;
    localparam int HEAT_W = 8;
    localparam int CFG_W  = 14;
    localparam int SUM_W  = 16;
    localparam int NT_W   = 17;
    localparam int NLIM_W = 14;
    localparam int DEV_W  = 18;
    localparam int DIFF_W = 15;
    localparam int ALU_W  = 19;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic signed [TEMP_W-1:0] NONE_TEMP   = 14'sd8000;
    localparam logic [HEAT_W-1:0]        HEAT_FAULT  = 8'hFF;
    localparam logic signed [TEMP_W-1:0] TARGET_RST  = 14'sd0;
    localparam logic [LIM_W-1:0]         LIMIT_RST   = 12'd160;
    localparam logic [HH_W-1:0]          HH_RST      = 10'd24;
    localparam logic signed [TEMP_W-1:0] FAULT_RST   = 14'sd4000;

    localparam logic [1:0] REG_TARGET  = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_HYST    = 2'd2;
    localparam logic [1:0] REG_FAULT   = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t                  op;
        logic signed [ALU_W-1:0]  a;
        logic signed [ALU_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic signed [ALU_W-1:0]  res;
        logic                     lt;
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/vsht_alu.sv
`default_nettype none

module vsht_alu
    import vsht_pkg::*;
(
    input  var alu_req_t req,
    output alu_rsp_t     rsp
);

    logic signed [ALU_W:0] a_x;
    logic signed [ALU_W:0] b_x;
    logic signed [ALU_W:0] r_x;

    always_comb
    begin
        a_x = (ALU_W+1)'(req.a);
        b_x = (ALU_W+1)'(req.b);
        unique case (req.op)
            ALU_SUB: r_x = a_x - b_x;
            default: r_x = a_x + b_x;
        endcase
        rsp.res = r_x[ALU_W-1:0];
        // sign of the extended difference gives a < b
        rsp.lt  = r_x[ALU_W];
    end

endmodule

`default_nettype wire

// File: rtl/voted_sensor_hysteresis_thermostat.sv
// sequencing: each request runs up to four voting passes over the enabled sensors, then
// the minimum, fault and band tests; a pass that rejects every sensor, or an empty enable
// mask, skips the minimum search; a new request is taken only after the last result is
// loaded, as the one shared adder/comparator steps through sum, deviation, minimum, fault
// and band tests; a result still held at the final step stalls the sequencer until taken
// reset: asynchronous, clears the sequencer and heater state, loads register defaults
`default_nettype none

module voted_sensor_hysteresis_thermostat
    import vsht_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_wr_en,
    input  wire  [1:0]             cfg_index,
    input  wire  [CFG_W-1:0]       cfg_data,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [IN_TDATA_W-1:0]  s_tdata,   // sensor_temp_0, sensor_temp_1, sensor_temp_2, sensor_temp_3
    input  wire  [NSENS-1:0]       s_tuser,   // sensor_enable_mask
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // heater_state, fused_temp, zero pad
    output logic                   m_tuser    // no_valid_sensor
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DEV,
        ST_CMP,
        ST_MIN,
        ST_FAULT,
        ST_DIFF,
        ST_LOW,
        ST_HIGH,
        ST_FIN
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [NSENS-1:0]          valid_reg;
    logic [NSENS-1:0]          keep_reg;
    logic                      changed_reg;
    logic                      first_reg;
    logic                      fault_hit_reg;
    logic                      low_hit_reg;
    logic                      high_hit_reg;
    logic [HEAT_W-1:0]         heat_state_reg;
    logic                      m_tvalid_reg;
    logic signed [TEMP_W-1:0]  out_fused_reg;
    logic                      out_none_reg;

    logic signed [TEMP_W-1:0]  target_reg;
    logic [LIM_W-1:0]          limit_reg;
    logic [HH_W-1:0]           hh_reg;
    logic signed [TEMP_W-1:0]  fault_lim_reg;

    logic signed [TEMP_W-1:0]  t_reg [NSENS];
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DEV_W-1:0]   d_reg;
    logic signed [TEMP_W-1:0]  fused_reg;
    logic signed [DIFF_W-1:0]  e_reg;

    logic [CNT_W-1:0]          n_act;
    logic signed [TEMP_W-1:0]  t_sel;
    logic signed [NT_W-1:0]    t_ext;
    logic signed [NT_W-1:0]    nt;
    logic [NLIM_W-1:0]         lim_ext;
    logic [NLIM_W-1:0]         nlim;
    logic signed [DEV_W-1:0]   abs_d;
    logic signed [HH_W:0]      hh_neg;
    logic                      reject;
    logic [NSENS-1:0]          keep_now;
    logic                      changed_now;
    logic                      out_free;
    logic                      out_load;
    logic [HEAT_W-1:0]         heat_next;
    logic                      last_idx;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    vsht_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        n_act    = CNT_W'($countones(valid_reg));
        t_sel    = t_reg[idx_reg];
        t_ext    = NT_W'(t_sel);
        lim_ext  = NLIM_W'(limit_reg);
        unique case (n_act)
            3'd0:    nt = '0;
            3'd1:    nt = t_ext;
            3'd2:    nt = t_ext <<< 1;
            3'd3:    nt = t_ext + (t_ext <<< 1);
            default: nt = t_ext <<< 2;
        endcase
        unique case (n_act)
            3'd0:    nlim = '0;
            3'd1:    nlim = lim_ext;
            3'd2:    nlim = lim_ext << 1;
            3'd3:    nlim = lim_ext + (lim_ext << 1);
            default: nlim = lim_ext << 2;
        endcase
        abs_d  = d_reg[DEV_W-1] ? -d_reg : d_reg;
        hh_neg = -$signed({1'b0, hh_reg});
        last_idx = (idx_reg == IDX_W'(NSENS - 1));
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            ST_SUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(sum_reg);
                alu_req.b  = valid_reg[idx_reg] ? ALU_W'(t_sel) : '0;
            end
            ST_DEV:
            begin
                alu_req.a = ALU_W'(sum_reg);
                alu_req.b = ALU_W'(nt);
            end
            ST_CMP:
            begin
                alu_req.a = $signed(ALU_W'(nlim));
                alu_req.b = ALU_W'(abs_d);
            end
            ST_MIN:
            begin
                alu_req.a = ALU_W'(t_sel);
                alu_req.b = ALU_W'(fused_reg);
            end
            ST_FAULT:
            begin
                alu_req.a = ALU_W'(fused_reg);
                alu_req.b = ALU_W'(fault_lim_reg);
            end
            ST_DIFF:
            begin
                alu_req.a = ALU_W'(fused_reg);
                alu_req.b = ALU_W'(target_reg);
            end
            ST_LOW:
            begin
                alu_req.a = ALU_W'(e_reg);
                alu_req.b = ALU_W'(hh_neg);
            end
            ST_HIGH:
            begin
                alu_req.a = $signed(ALU_W'(hh_reg));
                alu_req.b = ALU_W'(e_reg);
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        reject      = (state_reg == ST_CMP) && valid_reg[idx_reg] && alu_rsp.lt;
        keep_now    = keep_reg & ~(NSENS'(reject) << idx_reg);
        changed_now = changed_reg | reject;
        out_free    = !m_tvalid_reg || m_tready;
        out_load    = (state_reg == ST_FIN) && out_free;
        priority if (fault_hit_reg)
            heat_next = HEAT_FAULT;
        else if (low_hit_reg)
            heat_next = heat_state_reg | HEAT_W'(1);
        else if (high_hit_reg)
            heat_next = heat_state_reg & ~HEAT_W'(1);
        else
            heat_next = heat_state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            keep_reg       <= '0;
            changed_reg    <= 1'b0;
            first_reg      <= 1'b0;
            fault_hit_reg  <= 1'b0;
            low_hit_reg    <= 1'b0;
            high_hit_reg   <= 1'b0;
            heat_state_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            out_fused_reg  <= '0;
            out_none_reg   <= 1'b0;
            target_reg     <= TARGET_RST;
            limit_reg      <= LIMIT_RST;
            hh_reg         <= HH_RST;
            fault_lim_reg  <= FAULT_RST;
            for (int i = 0; i < NSENS; i++)
            begin
                t_reg[i] <= '0;
            end
            sum_reg        <= '0;
            d_reg          <= '0;
            fused_reg      <= '0;
            e_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_TARGET: target_reg    <= $signed(cfg_data);
                    REG_LIMIT:  limit_reg     <= cfg_data[LIM_W-1:0];
                    REG_HYST:   hh_reg        <= cfg_data[HH_W-1:0];
                    REG_FAULT:  fault_lim_reg <= $signed(cfg_data);
                    default:    ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < NSENS; i++)
                        begin
                            t_reg[i] <= s_tdata[i*TEMP_W +: TEMP_W];
                        end
                        valid_reg   <= s_tuser;
                        keep_reg    <= s_tuser;
                        changed_reg <= 1'b0;
                        first_reg   <= 1'b1;
                        sum_reg     <= '0;
                        fused_reg   <= NONE_TEMP;
                        idx_reg     <= '0;
                        state_reg   <= (s_tuser == '0) ? ST_FAULT : ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    sum_reg <= alu_rsp.res[SUM_W-1:0];
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        state_reg <= ST_DEV;
                    end
                end
                ST_DEV:
                begin
                    d_reg     <= alu_rsp.res[DEV_W-1:0];
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    keep_reg    <= keep_now;
                    changed_reg <= changed_now;
                    idx_reg     <= idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        valid_reg <= keep_now;
                        if (keep_now == '0)
                        begin
                            state_reg <= ST_FAULT;
                        end
                        else if (changed_now)
                        begin
                            // another pass over the survivors
                            sum_reg     <= '0;
                            changed_reg <= 1'b0;
                            state_reg   <= ST_SUM;
                        end
                        else
                        begin
                            state_reg <= ST_MIN;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DEV;
                    end
                end
                ST_MIN:
                begin
                    if (valid_reg[idx_reg] && (first_reg || alu_rsp.lt))
                    begin
                        fused_reg <= t_sel;
                        first_reg <= 1'b0;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        state_reg <= ST_FAULT;
                    end
                end
                ST_FAULT:
                begin
                    fault_hit_reg <= !alu_rsp.lt;
                    state_reg     <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    e_reg     <= alu_rsp.res[DIFF_W-1:0];
                    state_reg <= ST_LOW;
                end
                ST_LOW:
                begin
                    low_hit_reg <= alu_rsp.lt;
                    state_reg   <= ST_HIGH;
                end
                ST_HIGH:
                begin
                    high_hit_reg <= alu_rsp.lt;
                    state_reg    <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        heat_state_reg <= heat_next;
                        out_fused_reg  <= fused_reg;
                        out_none_reg   <= (valid_reg == '0);
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_fused_reg, heat_state_reg};
    assign m_tuser  = out_none_reg;

    // one request at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while sequencer busy");

    // surviving sensors always stay within the valid mask
    a_keep_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (keep_reg & ~valid_reg) == '0)
        else $error("keep mask outside valid mask");

    a_fault_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && fault_hit_reg |=> m_tdata[HEAT_W-1:0] == HEAT_FAULT)
        else $error("fault not reported");

    a_none_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && valid_reg == '0 |=> m_tuser && m_tdata[HEAT_W +: TEMP_W] == NONE_TEMP)
        else $error("empty survivor set not reported");

endmodule

`default_nettype wire

// File: bench/voted_sensor_hysteresis_thermostat_checker.sv
`default_nettype none

module voted_sensor_hysteresis_thermostat_checker
    import vsht_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_wr_en,
    input  wire  [1:0]             cfg_index,
    input  wire  [CFG_W-1:0]       cfg_data,
    input  wire                    s_tvalid,
    input  wire                    s_tready,
    input  wire  [IN_TDATA_W-1:0]  s_tdata,   // sensor_temp_0, sensor_temp_1, sensor_temp_2, sensor_temp_3
    input  wire  [NSENS-1:0]       s_tuser,   // sensor_enable_mask
    input  wire                    m_tvalid,
    input  wire                    m_tready,
    input  wire  [OUT_TDATA_W-1:0] m_tdata,   // heater_state, fused_temp, zero pad
    input  wire                    m_tuser,   // no_valid_sensor
    output int                     fail_count,
    output int                     pending,
    output int                     n_results,
    output int                     n_none,
    output int                     n_fault
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HEAT_W-1:0]        heater;
        logic signed [TEMP_W-1:0] fused;
        logic                     none;
    } thermo_result_t;

    thermo_result_t              expected_results[$];
    logic signed [TEMP_W-1:0]    target_q;
    logic [LIM_W-1:0]            limit_q;
    logic [HH_W-1:0]             hyst_q;
    logic signed [TEMP_W-1:0]    fault_q;
    logic [HEAT_W-1:0]           heater_q;
    int                          errors;
    int                          seen;
    int                          seen_none;
    int                          seen_fault;

    // iterative mean-deviation voting, then minimum of the survivors
    function automatic void vote_sensors(input logic [IN_TDATA_W-1:0] d,
                                         input logic [NSENS-1:0] mask,
                                         output int fused, output bit none);
        int t[NSENS];
        int sum;
        int n;
        int dev;
        logic [NSENS-1:0] alive;
        logic [NSENS-1:0] keep;
        bit changed;
        bit first;
        for (int i = 0; i < NSENS; i++)
            t[i] = $signed(d[i*TEMP_W +: TEMP_W]);
        alive = mask;
        changed = 1'b1;
        while (changed && alive != '0)
        begin
            sum = 0;
            n = 0;
            keep = alive;
            changed = 1'b0;
            for (int i = 0; i < NSENS; i++)
                if (alive[i])
                begin
                    sum += t[i];
                    n++;
                end
            for (int i = 0; i < NSENS; i++)
                if (alive[i])
                begin
                    dev = sum - n * t[i];
                    if (dev < 0)
                        dev = -dev;
                    if (dev > n * int'(limit_q))
                    begin
                        keep[i] = 1'b0;
                        changed = 1'b1;
                    end
                end
            alive = keep;
        end
        none = (alive == '0);
        fused = int'(NONE_TEMP);
        first = 1'b1;
        for (int i = 0; i < NSENS; i++)
            if (alive[i])
            begin
                if (first || t[i] < fused)
                    fused = t[i];
                first = 1'b0;
            end
    endfunction

    function automatic logic [HEAT_W-1:0] next_heater(input logic [HEAT_W-1:0] prev,
                                                     input int fused);
        if (fused >= int'(fault_q))
            return HEAT_FAULT;
        else if (fused < int'(target_q) - int'(hyst_q))
            return prev | 8'h01;
        else if (fused > int'(target_q) + int'(hyst_q))
            return prev & 8'hFE;
        return prev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        thermo_result_t want;
        thermo_result_t got;
        int fz;
        bit nv;
        if (!rst_n)
        begin
            target_q = TARGET_RST;
            limit_q  = LIMIT_RST;
            hyst_q   = HH_RST;
            fault_q  = FAULT_RST;
            heater_q = '0;
            expected_results.delete();
            errors = 0;
            seen = 0;
            seen_none = 0;
            seen_fault = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TARGET: target_q = cfg_data[TEMP_W-1:0];
                    REG_LIMIT:  limit_q  = cfg_data[LIM_W-1:0];
                    REG_HYST:   hyst_q   = cfg_data[HH_W-1:0];
                    REG_FAULT:  fault_q  = cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.heater = m_tdata[HEAT_W-1:0];
                got.fused  = m_tdata[HEAT_W +: TEMP_W];
                got.none   = m_tuser;
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: heater %02h fused %0d none %0b",
                                 got.heater, got.fused, got.none);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.heater != want.heater || got.fused != want.fused
                        || got.none != want.none)
                    begin
                        if (errors < 10)
                            $display({"result %0d: heater exp %02h got %02h, ",
                                      "fused exp %0d got %0d, none exp %0b got %0b"},
                                     seen, want.heater, got.heater, want.fused, got.fused,
                                     want.none, got.none);
                        errors++;
                    end
                    seen++;
                    if (want.none)
                        seen_none++;
                    if (want.heater == HEAT_FAULT)
                        seen_fault++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                vote_sensors(s_tdata, s_tuser, fz, nv);
                heater_q = next_heater(heater_q, fz);
                want.heater = heater_q;
                want.fused  = fz[TEMP_W-1:0];
                want.none   = nv;
                expected_results.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
        n_results  <= seen;
        n_none     <= seen_none;
        n_fault    <= seen_fault;
    end

endmodule

`default_nettype wire

// File: bench/voted_sensor_hysteresis_thermostat_tb.sv
`default_nettype none

module voted_sensor_hysteresis_thermostat_tb;

    import vsht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [1:0]             cfg_index = REG_TARGET;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [NSENS-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int  chk_fails;
    int  chk_pending;
    int  chk_results;
    int  chk_none;
    int  chk_fault;

    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  settings_used = 1;

    int  cur_target = 0;
    int  cur_limit = 160;
    int  cur_hyst = 24;
    int  cur_fault = 4000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    voted_sensor_hysteresis_thermostat i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    voted_sensor_hysteresis_thermostat_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (chk_fails),
        .pending    (chk_pending),
        .n_results  (chk_results),
        .n_none     (chk_none),
        .n_fault    (chk_fault)
    );

    // receiver back-pressure in bursts, held ready while recv_idle is clear
    always @(posedge clk)
    begin
        if (!recv_idle)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("voted_sensor_hysteresis_thermostat: mismatch");
            $finish;
        end
    end

    function automatic int clip14(input int v);
        if (v < -8192)
            return -8192;
        if (v > 8191)
            return 8191;
        return v;
    endfunction

    function automatic int spread_rand(input int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack4(input int a, input int b,
                                                    input int c, input int d);
        return {d[TEMP_W-1:0], c[TEMP_W-1:0], b[TEMP_W-1:0], a[TEMP_W-1:0]};
    endfunction

    function automatic void gen_reading(output logic [IN_TDATA_W-1:0] d,
                                        output logic [NSENS-1:0] mask);
        int t[NSENS];
        int centre;
        int spread;
        int j;
        logic [63:0] raw;
        case ($urandom_range(0, 9))
            0:
            begin
                raw = {$urandom, $urandom};
                d = raw[IN_TDATA_W-1:0];
                mask = NSENS'($urandom_range(0, 15));
                return;
            end
            1:
            begin
                for (int i = 0; i < NSENS; i++)
                    case ($urandom_range(0, 3))
                        0: t[i] = -8192;
                        1: t[i] = 8191;
                        2: t[i] = 0;
                        default: t[i] = -1;
                    endcase
                mask = NSENS'($urandom_range(0, 15));
                d = pack4(t[0], t[1], t[2], t[3]);
                return;
            end
            2: centre = clip14(cur_fault + spread_rand(20));
            default: centre = clip14(cur_target + spread_rand(cur_hyst + 64));
        endcase
        spread = cur_limit / 2 + 1;
        for (int i = 0; i < NSENS; i++)
            t[i] = clip14(centre + spread_rand(spread));
        if ($urandom_range(0, 9) < 3)
        begin
            j = $urandom_range(0, NSENS - 1);
            if ($urandom_range(0, 1) == 0)
                t[j] = clip14(t[j] + cur_limit + int'($urandom_range(1, 3 * cur_limit + 200)));
            else
                t[j] = clip14(t[j] - cur_limit - int'($urandom_range(1, 3 * cur_limit + 200)));
        end
        if ($urandom_range(0, 1) == 0)
            mask = '1;
        else
            mask = NSENS'($urandom_range(0, 15));
        d = pack4(t[0], t[1], t[2], t[3]);
    endfunction

    task automatic send_reading(input logic [IN_TDATA_W-1:0] d, input logic [NSENS-1:0] mask);
        logic [63:0] noise;
        s_tdata  <= d;
        s_tuser  <= mask;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (send_idle && $urandom_range(0, 5) == 0)
        begin
            noise = {$urandom, $urandom};
            s_tvalid <= 1'b0;
            s_tdata  <= noise[IN_TDATA_W-1:0];
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    // hold the sender until every request has been answered
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic load_settings(input int tgt, input int lim, input int hy, input int flt);
        logic [1:0]       regs[4];
        logic [CFG_W-1:0] vals[4];
        logic [1:0]       junk_lim;
        logic [3:0]       junk_hy;
        junk_lim = 2'($urandom);
        junk_hy  = 4'($urandom);
        regs[0] = REG_TARGET;
        regs[1] = REG_LIMIT;
        regs[2] = REG_HYST;
        regs[3] = REG_FAULT;
        vals[0] = tgt[TEMP_W-1:0];
        vals[1] = {junk_lim, lim[LIM_W-1:0]};
        vals[2] = {junk_hy, hy[HH_W-1:0]};
        vals[3] = flt[TEMP_W-1:0];
        for (int r = 0; r < 4; r++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cur_target = tgt;
        cur_limit  = lim;
        cur_hyst   = hy;
        cur_fault  = flt;
        settings_used++;
    endtask

    initial
    begin
        logic [IN_TDATA_W-1:0] d;
        logic [NSENS-1:0]      mask;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, target 0, band 24, fault 4000, limit 160
        send_reading(pack4(0, 0, 0, 0), 4'h0);
        send_reading(pack4(-16, -16, -16, -16), 4'hF);
        send_reading(pack4(100, 110, 120, 130), 4'hF);
        send_reading(pack4(10, 0, 0, 0), 4'h1);
        send_reading(pack4(-24, 0, 0, 0), 4'h1);
        send_reading(pack4(-25, 0, 0, 0), 4'h1);
        send_reading(pack4(24, 0, 0, 0), 4'h1);
        send_reading(pack4(25, 0, 0, 0), 4'h1);
        send_reading(pack4(3999, 0, 0, 0), 4'h1);
        send_reading(pack4(4000, 0, 0, 0), 4'h1);
        send_reading(pack4(0, -30, 0, 0), 4'h2);
        send_reading(pack4(0, 0, 60, 0), 4'h4);
        send_reading(pack4(0, 0, 0, -8192), 4'h8);
        send_reading(pack4(-8192, -8192, -8192, -8192), 4'hF);
        send_reading(pack4(8191, 8191, 8191, 8191), 4'hF);
        send_reading(pack4(-8192, 8191, -8192, 8191), 4'hF);
        send_reading(pack4(0, 320, 0, 0), 4'h3);
        send_reading(pack4(0, 321, 0, 0), 4'h3);
        send_reading(pack4(0, 0, 100, 400), 4'hF);
        send_reading(pack4(0, 30, 200, 900), 4'hF);
        send_reading(pack4(100, 105, 110, 1500), 4'hF);
        send_reading(pack4(-8192, 8191, 0, -1), 4'h0);
        send_reading(pack4(-40, -35, 7000, -30), 4'hB);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_readings();
            case (phase)
                0: load_settings(800, 160, 24, 4000);
                1: load_settings(-8192, 0, 0, 8191);
                2: load_settings(8191, 4095, 1023, -8192);
                3: load_settings(0, 4095, 0, 8191);
                5: load_settings(-300, 20, 1023, 2000);
                7: load_settings(100, 160, 8, 4000);
                default: load_settings(spread_rand(3000), $urandom_range(0, 600),
                                       $urandom_range(0, 200), spread_rand(8000));
            endcase
            send_idle = (phase != PHASES - 1) && (phase != 3);
            recv_idle = (phase != PHASES - 1) && (phase != 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                gen_reading(d, mask);
                send_reading(d, mask);
            end
        end

        drain_readings();
        $display("checked %0d readings over %0d register settings", chk_results, settings_used);
        $display("%0d with no surviving sensor, %0d reporting fault", chk_none, chk_fault);
        if (chk_fails == 0 && chk_pending == 0)
            $display("voted_sensor_hysteresis_thermostat: match");
        else
            $display("voted_sensor_hysteresis_thermostat: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/vsht_pkg.sv
rtl/vsht_alu.sv
rtl/voted_sensor_hysteresis_thermostat.sv
bench/voted_sensor_hysteresis_thermostat_checker.sv
bench/voted_sensor_hysteresis_thermostat_tb.sv
